FILE: rtl/rrts_pkg.sv
package rrts_pkg;

   localparam int TID_W   = 4;
   localparam int TIME_W  = 64;
   localparam int COUNT_W = 32;

   typedef enum logic [1:0] {
      OP_RUNNABLE = 2'd0,
      OP_WAITING  = 2'd1,
      OP_ZOMBIE   = 2'd2,
      OP_SCHEDULE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STS_DONE    = 2'd0,
      STS_ILLEGAL = 2'd1,
      STS_EMPTY   = 2'd2
   } status_type;

   // per-thread scheduling state, stored as data in the thread table
   typedef enum logic [2:0] {
      TS_NEW      = 3'd0,
      TS_RUNNABLE = 3'd1,
      TS_RUNNING  = 3'd2,
      TS_WAITING  = 3'd3,
      TS_ZOMBIE   = 3'd4
   } thread_state_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [TID_W-1:0]    thread_id;
      logic [TIME_W-1:0]   now_ns;
   } req_payload_type;

   typedef struct packed {
      status_type          status;
      logic [TID_W-1:0]    running_thread;
      logic [TID_W-1:0]    previous_thread;
      logic                switched;
      logic [TIME_W-1:0]   thread_wait_ns;
      logic [COUNT_W-1:0]  switch_count;
   } rsp_payload_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } fifo_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

endpackage

FILE: rtl/rrts_if.sv
interface rrts_req_if
   import rrts_pkg::*;
   ;
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rrts_rsp_if
   import rrts_pkg::*;
   ;
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/round_robin_thread_scheduler_unit.sv
//  channel   dir  handshake            payload
//  req_chan  in   valid / ready        opcode, thread_id, now_ns
//  rsp_chan  out  valid / ready        status, running/previous thread, switched,
//                                      thread_wait_ns, switch_count
//  csr       in   csr_we (no ready)    csr_wdata = boot_thread
//
//  One transaction per cycle while rsp_chan is not stalled: input register, one pass
//  of table and queue logic, result register. Reset and any csr write restart the
//  scheduler; the tables use per-thread valid bits. A stalled rsp holds the pipe and
//  drops req_chan.ready once the input register is full.
module round_robin_thread_scheduler_unit
   import rrts_pkg::*;
#(
   parameter int NUM_THREADS = 16
) (
   input  logic              clock,
   input  logic              reset,
   rrts_req_if.sink          req_chan,
   rrts_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [TID_W-1:0]  csr_wdata
);

   // thread ids are 4 bits wide, so at most 16 threads can ever be named
   localparam int SLOTS = (NUM_THREADS < 16) ? NUM_THREADS : 16;
   localparam int IDX_W = $clog2(SLOTS);

   logic                  s1_vld_ff, s1_vld_in;
   req_payload_type       s1_ff;
   logic                  rsp_vld_ff, rsp_vld_in;
   rsp_payload_type       rsp_ff, rsp_in;
   logic                  advance;
   logic                  req_accept;

   thread_state_type      state_ff [SLOTS];
   thread_state_type      state_in [SLOTS];
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic                  cur_run_ff, cur_run_in;
   logic [TIME_W-1:0]     wait_total_ff [SLOTS];
   logic [TIME_W-1:0]     wait_base_ff [SLOTS];
   logic [COUNT_W-1:0]    switches_ff [SLOTS];
   logic [SLOTS-1:0]      tot_vld_ff;
   logic [SLOTS-1:0]      sw_vld_ff;

   logic                  restart;
   logic [IDX_W-1:0]      boot_idx;

   fifo_ctl_type          fifo_ctl;
   fifo_stat_type         fifo_stat;
   logic [IDX_W-1:0]      push_id;
   logic [IDX_W-1:0]      nxt_id;
   logic                  push_req, pop_req;

   logic [IDX_W-1:0]      tid_idx;
   logic                  tid_ok;
   thread_state_type      st;
   logic [IDX_W-1:0]      rd_idx;
   logic [TIME_W-1:0]     tot_rd;
   logic [COUNT_W-1:0]    sw_rd;
   logic                  tot_we, base_we, sw_we;
   logic [TIME_W-1:0]     wait_total_in;
   logic [TIME_W-1:0]     wait_base_in;
   logic [COUNT_W-1:0]    switches_in;

   assign req_accept     = req_chan.valid && req_chan.ready;
   assign advance        = s1_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_vld_ff || advance;
   assign s1_vld_in      = req_accept || (s1_vld_ff && !advance);
   assign rsp_vld_in     = advance || (rsp_vld_ff && !rsp_chan.ready);

   assign restart  = reset || csr_we;
   assign boot_idx = (!reset && (32'(csr_wdata) < NUM_THREADS)) ?
                     csr_wdata[IDX_W-1:0] : '0;

   assign tid_idx = s1_ff.thread_id[IDX_W-1:0];
   assign tid_ok  = 32'(s1_ff.thread_id) < NUM_THREADS;
   assign st      = state_ff[tid_idx];

   assign tot_rd = tot_vld_ff[rd_idx] ? wait_total_ff[rd_idx] : '0;
   assign sw_rd  = sw_vld_ff[rd_idx]  ? switches_ff[rd_idx]   : '0;

   assign wait_total_in = s1_ff.now_ns + wait_base_ff[tid_idx];
   assign wait_base_in  = tot_rd - s1_ff.now_ns;
   assign switches_in   = sw_rd + COUNT_W'(1);

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      cur_run_in = cur_run_ff;
      push_req   = 1'b0;
      pop_req    = 1'b0;
      push_id    = cur_ff;
      tot_we     = 1'b0;
      base_we    = 1'b0;
      sw_we      = 1'b0;
      rd_idx     = tid_idx;
      rsp_in     = '0;
      rsp_in.status          = STS_DONE;
      rsp_in.previous_thread = TID_W'(cur_ff);

      case (s1_ff.opcode)
         OP_SCHEDULE: begin
            if (fifo_stat.empty) begin
               rsp_in.status = STS_EMPTY;
               rd_idx        = cur_ff;
            end else begin
               pop_req          = 1'b1;
               rd_idx           = nxt_id;
               sw_we            = 1'b1;
               state_in[nxt_id] = TS_RUNNING;
               cur_in           = nxt_id;
               cur_run_in       = 1'b1;
               if (nxt_id != cur_ff) begin
                  rsp_in.switched = 1'b1;
                  if (cur_run_ff) begin
                     state_in[cur_ff] = TS_RUNNABLE;
                     push_req         = 1'b1;
                  end
               end
            end
         end
         OP_RUNNABLE: begin
            if (!tid_ok || st == TS_RUNNABLE || st == TS_ZOMBIE || fifo_stat.full) begin
               rsp_in.status = STS_ILLEGAL;
            end else begin
               tot_we            = (st == TS_WAITING);
               state_in[tid_idx] = TS_RUNNABLE;
               push_req          = 1'b1;
               push_id           = tid_idx;
               if (st == TS_RUNNING) begin
                  cur_run_in = 1'b0;
               end
            end
         end
         default: begin
            if (!tid_ok || st != TS_RUNNING) begin
               rsp_in.status = STS_ILLEGAL;
            end else begin
               cur_run_in = 1'b0;
               if (s1_ff.opcode == OP_WAITING) begin
                  state_in[tid_idx] = TS_WAITING;
                  base_we           = 1'b1;
               end else begin
                  state_in[tid_idx] = TS_ZOMBIE;
               end
            end
         end
      endcase

      rsp_in.running_thread = TID_W'(cur_in);
      if (s1_ff.opcode == OP_SCHEDULE || tid_ok) begin
         rsp_in.thread_wait_ns = tot_we ? wait_total_in : tot_rd;
         rsp_in.switch_count   = sw_we ? switches_in : sw_rd;
      end
   end

   assign fifo_ctl.clear = restart;
   assign fifo_ctl.push  = advance && push_req && !restart;
   assign fifo_ctl.pop   = advance && pop_req && !restart;

   rrts_fifo #(
      .DEPTH (SLOTS)
   ) u_rrts_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctl     (fifo_ctl),
      .push_id (push_id),
      .head_id (nxt_id),
      .stat    (fifo_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= req_chan.data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (restart) begin
         for (int i = 0; i < SLOTS; i++) begin
            state_ff[i] <= (IDX_W'(i) == boot_idx) ? TS_RUNNING : TS_NEW;
         end
         cur_ff     <= boot_idx;
         cur_run_ff <= 1'b1;
         tot_vld_ff <= '0;
         sw_vld_ff  <= '0;
      end else if (advance) begin
         state_ff   <= state_in;
         cur_ff     <= cur_in;
         cur_run_ff <= cur_run_in;
         if (tot_we) begin
            tot_vld_ff[tid_idx] <= 1'b1;
         end
         if (sw_we) begin
            sw_vld_ff[rd_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && !restart) begin
         if (tot_we) begin
            wait_total_ff[tid_idx] <= wait_total_in;
         end
         if (base_we) begin
            wait_base_ff[tid_idx] <= wait_base_in;
         end
         if (sw_we) begin
            switches_ff[rd_idx] <= switches_in;
         end
      end
   end

   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.data  = rsp_ff;

endmodule

FILE: rtl/rrts_fifo.sv
module rrts_fifo
   import rrts_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fifo_ctl_type             ctl,
   input  logic [$clog2(DEPTH)-1:0] push_id,
   output logic [$clog2(DEPTH)-1:0] head_id,
   output fifo_stat_type            stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [PTR_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   always_comb begin
      head_in  = ctl.pop  ? next_slot(head_ff) : head_ff;
      tail_in  = ctl.push ? next_slot(tail_ff) : tail_ff;
      count_in = count_ff;
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop && !ctl.push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[tail_ff] <= push_id;
      end
   end

   assign head_id    = mem_ff[head_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(DEPTH));

endmodule

FILE: rtl/rrts_checker.sv
module rrts_checker
   import rrts_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_data
);

   // stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   a_switch_moves: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.switched |->
         rsp_data.status == STS_DONE &&
         rsp_data.running_thread != rsp_data.previous_thread)
      else $error("switch reported without a thread change");

   a_no_switch_keeps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.switched && rsp_data.status != STS_DONE |->
         rsp_data.running_thread == rsp_data.previous_thread)
      else $error("running thread changed on an ignored transaction");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == STS_DONE || rsp_data.status == STS_ILLEGAL ||
         rsp_data.status == STS_EMPTY)
      else $error("rsp transaction carries an undefined status");

endmodule

bind round_robin_thread_scheduler_unit rrts_checker u_rrts_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
